// ===== src/f84tp_pkg.sv =====
// Shared types, constants and saturating helpers for the F84 transition block.
// No dependencies; imported by every module of the block.

package f84tp_pkg;

    // Number formats
    localparam int FRAC_BITS   = 24;
    localparam int VALUE_WIDTH = 32;
    localparam int FREQ_W      = 25;
    localparam int WORD_W      = 32;
    localparam int EXP_SHIFT   = 62 - FRAC_BITS;
    localparam int SER_TERMS   = 21;
    localparam int NUM_POW     = 6;

    localparam logic [63:0] QF_ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] Q62_ONE = 64'd1 << 62;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;

    // Operation codes
    localparam logic [1:0] OP_PROB = 2'd0;
    localparam logic [1:0] OP_D1   = 2'd1;
    localparam logic [1:0] OP_D2   = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_FREQ_A = 3'd0;
    localparam logic [2:0] CFG_FREQ_C = 3'd1;
    localparam logic [2:0] CFG_FREQ_G = 3'd2;
    localparam logic [2:0] CFG_FREQ_T = 3'd3;
    localparam logic [2:0] CFG_KAPPA  = 3'd4;
    localparam logic [2:0] CFG_RATE   = 3'd5;
    localparam logic [2:0] CFG_PUR    = 3'd6;
    localparam logic [2:0] CFG_PYR    = 3'd7;

    typedef struct packed {
        logic [1:0]        op;
        logic              null_op;
        logic              whole;
        logic [1:0]        row_sel;
        logic [1:0]        col_sel;
        logic [WORD_W-1:0] distance;
    } t_item;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_a;
        logic [FREQ_W-1:0] freq_c;
        logic [FREQ_W-1:0] freq_g;
        logic [FREQ_W-1:0] freq_t;
        logic [WORD_W-1:0] kappa;
        logic [WORD_W-1:0] rate;
        logic [FREQ_W-1:0] pur;
        logic [FREQ_W-1:0] pyr;
    } t_cfg;

    typedef struct packed {
        logic [1:0]             row;
        logic [1:0]             col;
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic               start;
        logic               s62;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_mul_req;

    function automatic logic [63:0] f_mag(input logic signed [63:0] a);
        logic [63:0] m;
        m = a[63] ? 64'(-a) : 64'(a);
        return m;
    endfunction

    function automatic logic signed [63:0] f_sneg(input logic signed [63:0] a);
        logic signed [63:0] r;
        r = (a == S64_MIN) ? S64_MAX : -a;
        return r;
    endfunction

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) r = s[64] ? S64_MIN : S64_MAX;
        else                r = s[63:0];
        return r;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] f_clamp(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > VAL_MAX) c = VAL_MAX;
        if (v < VAL_MIN) c = VAL_MIN;
        return c[VALUE_WIDTH-1:0];
    endfunction

endpackage

// ===== src/f84tp_front.sv =====
// Front end: two-entry request queue with op classification.
// Depends on f84tp_pkg.

module f84tp_front import f84tp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_op,
    input  logic              i_whole_matrix,
    input  logic [1:0]        i_row_sel,
    input  logic [1:0]        i_col_sel,
    input  logic [WORD_W-1:0] i_distance,
    output t_item             o_item,
    output logic              o_valid,
    input  logic              i_take
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;
    t_item      in_item;

    // Classify: unknown op codes produce zero-valued entries
    always_comb begin
        in_item.op       = i_op;
        in_item.null_op  = (i_op != OP_PROB) && (i_op != OP_D1) && (i_op != OP_D2);
        in_item.whole    = i_whole_matrix;
        in_item.row_sel  = i_row_sel;
        in_item.col_sel  = i_col_sel;
        in_item.distance = i_distance;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_valid;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= in_item;
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

endmodule

// ===== src/f84tp_mul.sv =====
// Shared 64x64 fixed-point multiplier: four 32x32 partial products, then
// round half away from zero, shift and saturate. Depends on f84tp_pkg.

module f84tp_mul import f84tp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    output logic signed [63:0] o_res,
    output logic               o_done
);

    logic [63:0]  r_am, r_bm;
    logic         r_neg, r_s62, r_busy;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic [31:0]  a_half, b_half;
    logic [63:0]  part;
    logic [127:0] part_sh, rsum, q;
    logic signed [63:0] res;

    // Partial product for this cycle
    always_comb begin
        a_half = r_cnt[1] ? r_am[63:32] : r_am[31:0];
        b_half = r_cnt[0] ? r_bm[63:32] : r_bm[31:0];
        part   = 64'(a_half) * 64'(b_half);
        case (r_cnt[1:0])
            2'd0:    part_sh = {64'd0, part};
            2'd3:    part_sh = {part, 64'd0};
            default: part_sh = {32'd0, part, 32'd0};
        endcase
    end

    // Rounding, sign and saturation
    always_comb begin
        rsum = r_acc + (r_s62 ? (128'd1 << 61) : (128'd1 << (FRAC_BITS - 1)));
        q    = r_s62 ? (rsum >> 62) : (rsum >> FRAC_BITS);
        if (r_neg) res = (|q[127:63]) ? S64_MIN : -$signed(q[63:0]);
        else       res = (|q[127:63]) ? S64_MAX : $signed(q[63:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_am  <= f_mag(i_req.a);
            r_bm  <= f_mag(i_req.b);
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_s62 <= i_req.s62;
            r_acc <= '0;
        end else if (r_busy && r_cnt != 3'd4) begin
            r_acc <= r_acc + part_sh;
        end
        if (r_busy && r_cnt == 3'd4) o_res <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

endmodule

// ===== src/f84tp_div.sv =====
// Shared restoring divider, 64-bit dividend by 25-bit divisor, four
// quotient bits per cycle. Depends on f84tp_pkg.

module f84tp_div import f84tp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_num,
    input  logic [FREQ_W-1:0] i_den,
    output logic [63:0]       o_quo,
    output logic              o_done
);

    logic [63:0]       r_num;
    logic [FREQ_W-1:0] r_rem, r_den;
    logic [3:0]        r_cnt;
    logic              r_busy;
    logic [63:0]       n_num, n_quo;
    logic [FREQ_W-1:0] n_rem;
    logic [FREQ_W:0]   rem2;

    // Four restoring steps
    always_comb begin
        n_num = r_num;
        n_quo = o_quo;
        n_rem = r_rem;
        rem2  = '0;
        for (int s = 0; s < 4; s++) begin
            rem2  = {n_rem, n_num[63]};
            n_num = {n_num[62:0], 1'b0};
            if (rem2 >= {1'b0, r_den}) begin
                n_rem = FREQ_W'(rem2 - {1'b0, r_den});
                n_quo = {n_quo[62:0], 1'b1};
            end else begin
                n_rem = rem2[FREQ_W-1:0];
                n_quo = {n_quo[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= (i_den == '0) ? FREQ_W'(1) : i_den;
            r_rem <= '0;
            o_quo <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            o_quo <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/f84tp_core.sv =====
// Back end: sequencer over the shared multiplier and divider, computing the
// exponentials, coefficients and matrix entries, plus a two-entry result
// queue. Depends on f84tp_pkg, f84tp_mul, f84tp_div.

module f84tp_core import f84tp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_item_valid,
    output logic    o_item_pop,
    input  t_cfg    i_cfg,
    output t_result o_result,
    output logic    o_empty,
    input  logic    i_pop
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_SER_M = 4'd2;
    localparam logic [3:0] ST_SER_D = 4'd3;
    localparam logic [3:0] ST_PSQ   = 4'd4;
    localparam logic [3:0] ST_LEN   = 4'd5;
    localparam logic [3:0] ST_EXP   = 4'd6;
    localparam logic [3:0] ST_EXP_P = 4'd7;
    localparam logic [3:0] ST_LEN2  = 4'd8;
    localparam logic [3:0] ST_R2    = 4'd9;
    localparam logic [3:0] ST_K2SQ  = 4'd10;
    localparam logic [3:0] ST_DIV   = 4'd11;
    localparam logic [3:0] ST_ENT   = 4'd12;
    localparam logic [3:0] ST_EMIT  = 4'd13;

    localparam logic [1:0] CTX_INIT = 2'd0;
    localparam logic [1:0] CTX_E1   = 2'd1;
    localparam logic [1:0] CTX_E2   = 2'd2;

    localparam logic [1:0] DST_A = 2'd0;
    localparam logic [1:0] DST_T = 2'd1;
    localparam logic [1:0] DST_V = 2'd2;

    logic [3:0]  r_state;
    logic [1:0]  r_ctx;
    logic        r_busy, r_pw_ok;
    logic [63:0] r_pw [NUM_POW];
    logic [2:0]  r_b, r_dk;
    logic [63:0] r_term, r_sum, r_xq, r_arg, r_l;
    logic [4:0]  r_n;
    logic [5:0]  r_ip;
    logic signed [63:0] r_e1, r_e2, r_r2, r_k2sq, r_qa, r_qb, r_a, r_t, r_v;
    logic signed [63:0] r_qp [4];
    t_item       r_item;
    logic [3:0]  r_k;
    logic [2:0]  r_ms;

    // Result queue
    t_result    r_oq [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       oq_push, oq_pop;
    t_result    out_res;

    // Shared units
    t_mul_req           m_req;
    logic signed [63:0] m_res;
    logic               m_done;
    logic               d_go, d_done;
    logic [63:0]        d_num, d_quo;
    logic [FREQ_W-1:0]  d_den;

    logic [63:0] k2, pw_b, ser_sum, exp_res;
    logic        ip_bit, ser_end;

    // Entry decode
    logic [1:0]         e_i, e_j, e_cidx;
    logic               e_diff, e_same_ij, e_nomul, e_fin, e_neg, e_last;
    logic [1:0]         e_dst;
    logic [FREQ_W-1:0]  e_freq;
    logic signed [63:0] e_pj, e_qos, e_c, e_ma, e_mb, e_val, e_r, e_k;
    logic [1:0]         op;

    f84tp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (m_req),
        .o_res   (m_res),
        .o_done  (m_done)
    );

    f84tp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_go),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_quo   (d_quo),
        .o_done  (d_done)
    );

    // Common terms
    always_comb begin
        k2      = 64'(i_cfg.kappa) + QF_ONE;
        pw_b    = r_pw[r_b];
        ip_bit  = (r_b != 3'd6) && r_ip[r_b];
        ser_sum = r_n[0] ? ((r_sum >= d_quo) ? r_sum - d_quo : 64'd0) : r_sum + d_quo;
        ser_end = (r_n == 5'(SER_TERMS));
        exp_res = (r_sum + (64'd1 << (EXP_SHIFT - 1))) >> EXP_SHIFT;
    end

    // Entry selection and step table
    always_comb begin
        op        = r_item.op;
        e_i       = r_item.whole ? r_k[3:2] : r_item.row_sel;
        e_j       = r_item.whole ? r_k[1:0] : r_item.col_sel;
        e_last    = !r_item.whole || (&r_k);
        e_diff    = e_i[0] ^ e_j[0];
        e_same_ij = (e_i == e_j);
        case (e_j)
            2'd0:    e_freq = i_cfg.freq_a;
            2'd1:    e_freq = i_cfg.freq_c;
            2'd2:    e_freq = i_cfg.freq_g;
            default: e_freq = i_cfg.freq_t;
        endcase
        e_pj   = $signed(64'(e_freq));
        e_qos  = e_i[0] ? r_qb : r_qa;
        e_cidx = e_same_ij ? (e_j ^ 2'd2) : e_j;
        e_c    = e_same_ij ? r_qp[e_cidx] : f_sneg(r_qp[e_cidx]);
        e_r    = (op == OP_D1) ? $signed(64'(i_cfg.rate)) : r_r2;
        e_k    = (op == OP_D1) ? $signed(k2) : r_k2sq;

        e_nomul = 1'b0;
        e_val   = '0;
        e_fin   = 1'b0;
        e_neg   = 1'b0;
        e_dst   = DST_T;
        e_ma    = '0;
        e_mb    = '0;
        if (r_item.null_op) begin
            e_nomul = 1'b1;
            e_fin   = 1'b1;
        end else if (e_diff) begin
            // Entry between classes
            if (r_ms == 3'd0) begin
                e_ma = e_pj;
                if (op == OP_PROB) begin
                    e_mb  = $signed(QF_ONE) - r_e1;
                    e_dst = DST_V;
                    e_fin = 1'b1;
                end else begin
                    e_mb  = r_e1;
                    e_dst = DST_A;
                end
            end else begin
                e_ma  = e_r;
                e_mb  = r_a;
                e_dst = DST_V;
                e_fin = 1'b1;
                e_neg = (op == OP_D2);
            end
        end else begin
            // Entry within a class
            case (r_ms)
                3'd0: begin
                    e_ma  = e_pj;
                    e_mb  = e_qos;
                    e_dst = DST_T;
                end
                3'd1: begin
                    e_ma  = r_t;
                    e_mb  = r_e1;
                    e_dst = DST_A;
                end
                3'd2: begin
                    e_ma  = e_c;
                    e_mb  = (op == OP_PROB) ? r_e2 : e_k;
                    e_dst = DST_T;
                end
                3'd3: begin
                    if (op == OP_PROB) begin
                        e_nomul = 1'b1;
                        e_fin   = 1'b1;
                        e_val   = f_sadd(f_sadd(e_pj, r_a), r_t);
                    end else begin
                        e_ma  = r_t;
                        e_mb  = r_e2;
                        e_dst = DST_T;
                    end
                end
                default: begin
                    e_ma  = e_r;
                    e_mb  = (op == OP_D1) ? f_sadd(f_sneg(r_a), f_sneg(r_t))
                                          : f_sadd(r_a, r_t);
                    e_dst = DST_V;
                    e_fin = 1'b1;
                end
            endcase
        end
    end

    // Unit requests per state
    always_comb begin
        m_req = '0;
        d_go  = 1'b0;
        d_num = '0;
        d_den = '0;
        case (r_state)
            ST_SER_M: begin
                m_req.a = r_term; m_req.b = r_xq; m_req.s62 = 1'b1;
                m_req.start = !r_busy;
            end
            ST_SER_D: begin
                d_num = r_term; d_den = FREQ_W'(r_n); d_go = !r_busy;
            end
            ST_PSQ: begin
                m_req.a = pw_b; m_req.b = pw_b; m_req.s62 = 1'b1;
                m_req.start = !r_busy;
            end
            ST_EXP_P: begin
                m_req.a = r_sum; m_req.b = pw_b; m_req.s62 = 1'b1;
                m_req.start = !r_busy && ip_bit;
            end
            ST_LEN: begin
                m_req.a = 64'(i_cfg.rate); m_req.b = 64'(r_item.distance);
                m_req.start = !r_busy;
            end
            ST_LEN2: begin
                m_req.a = k2; m_req.b = r_l; m_req.start = !r_busy;
            end
            ST_R2: begin
                m_req.a = 64'(i_cfg.rate); m_req.b = 64'(i_cfg.rate);
                m_req.start = !r_busy;
            end
            ST_K2SQ: begin
                m_req.a = k2; m_req.b = k2; m_req.start = !r_busy;
            end
            ST_DIV: begin
                d_go = !r_busy;
                case (r_dk)
                    3'd0: begin d_num = {15'd0, i_cfg.pyr, 24'd0}; d_den = i_cfg.pur; end
                    3'd1: begin d_num = {15'd0, i_cfg.pur, 24'd0}; d_den = i_cfg.pyr; end
                    3'd2: begin d_num = {15'd0, i_cfg.freq_a, 24'd0}; d_den = i_cfg.pur; end
                    3'd3: begin d_num = {15'd0, i_cfg.freq_c, 24'd0}; d_den = i_cfg.pyr; end
                    3'd4: begin d_num = {15'd0, i_cfg.freq_g, 24'd0}; d_den = i_cfg.pur; end
                    default: begin d_num = {15'd0, i_cfg.freq_t, 24'd0}; d_den = i_cfg.pyr; end
                endcase
            end
            ST_ENT: begin
                m_req.a = e_ma; m_req.b = e_mb; m_req.start = !r_busy && !e_nomul;
            end
            default: ;
        endcase
    end

    assign o_item_pop = (r_state == ST_IDLE) && r_pw_ok && i_item_valid;

    // Result formatting and queue control
    always_comb begin
        out_res.row   = e_i;
        out_res.col   = e_j;
        out_res.value = f_clamp(r_v);
        out_res.last  = e_last;
    end
    assign oq_push  = (r_state == ST_EMIT) && (r_ocnt != 2'd2);
    assign oq_pop   = i_pop && !o_empty;
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (oq_push) r_oq[r_owp] <= out_res;
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (o_item_pop) r_item <= i_item;
            ST_INIT: begin
                r_xq <= Q62_ONE; r_term <= Q62_ONE; r_sum <= Q62_ONE; r_n <= 5'd1;
            end
            ST_SER_M: if (m_done) r_term <= m_res;
            ST_SER_D: if (d_done) begin
                r_term <= d_quo;
                if (ser_end) begin
                    if (r_ctx == CTX_INIT) r_pw[0] <= ser_sum;
                    else                   r_sum <= ser_sum;
                    r_b <= 3'd0;
                end else begin
                    r_sum <= ser_sum;
                    r_n   <= r_n + 5'd1;
                end
            end
            ST_PSQ: if (m_done) begin
                r_pw[r_b + 3'd1] <= m_res;
                r_b <= r_b + 3'd1;
            end
            ST_LEN: if (m_done) begin
                r_l <= m_res; r_arg <= m_res;
            end
            ST_LEN2: if (m_done) r_arg <= m_res;
            ST_EXP: begin
                if (|r_arg[63:30]) begin
                    if (r_ctx == CTX_E1) r_e1 <= '0;
                    else                 r_e2 <= '0;
                end
                r_ip   <= r_arg[29:24];
                r_xq   <= {2'd0, r_arg[23:0], 38'd0};
                r_term <= Q62_ONE;
                r_sum  <= Q62_ONE;
                r_n    <= 5'd1;
            end
            ST_EXP_P: begin
                if (r_b == 3'd6) begin
                    if (r_ctx == CTX_E1) r_e1 <= $signed(exp_res);
                    else                 r_e2 <= $signed(exp_res);
                end else if (!ip_bit) begin
                    r_b <= r_b + 3'd1;
                end else if (m_done) begin
                    r_sum <= m_res;
                    r_b   <= r_b + 3'd1;
                end
            end
            ST_R2: if (m_done) r_r2 <= m_res;
            ST_K2SQ: if (m_done) begin
                r_k2sq <= m_res; r_dk <= 3'd0;
            end
            ST_DIV: if (d_done) begin
                case (r_dk)
                    3'd0:    r_qa <= $signed(d_quo);
                    3'd1:    r_qb <= $signed(d_quo);
                    default: r_qp[2'(r_dk - 3'd2)] <= $signed(d_quo);
                endcase
                r_dk <= r_dk + 3'd1;
                if (r_dk == 3'd5) begin
                    r_k <= 4'd0; r_ms <= 3'd0;
                end
            end
            ST_ENT: begin
                if (e_nomul) begin
                    r_v <= e_val;
                end else if (m_done) begin
                    case (e_dst)
                        DST_A:   r_a <= m_res;
                        DST_T:   r_t <= m_res;
                        default: r_v <= e_neg ? f_sneg(m_res) : m_res;
                    endcase
                    if (!e_fin) r_ms <= r_ms + 3'd1;
                end
            end
            ST_EMIT: if (oq_push) begin
                r_k <= r_k + 4'd1; r_ms <= 3'd0;
            end
            default: ;
        endcase
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ctx   <= CTX_INIT;
            r_busy  <= 1'b0;
            r_pw_ok <= 1'b0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            if (m_req.start || d_go)  r_busy <= 1'b1;
            else if (m_done || d_done) r_busy <= 1'b0;

            if (oq_push) r_owp <= !r_owp;
            if (oq_pop)  r_orp <= !r_orp;
            r_ocnt <= r_ocnt + 2'(oq_push) - 2'(oq_pop);

            case (r_state)
                ST_IDLE: begin
                    if (!r_pw_ok) begin
                        r_state <= ST_INIT;
                        r_ctx   <= CTX_INIT;
                    end else if (o_item_pop) begin
                        r_state <= ST_LEN;
                    end
                end
                ST_INIT:  r_state <= ST_SER_M;
                ST_SER_M: if (m_done) r_state <= ST_SER_D;
                ST_SER_D: if (d_done) begin
                    if (!ser_end)              r_state <= ST_SER_M;
                    else if (r_ctx == CTX_INIT) r_state <= ST_PSQ;
                    else                       r_state <= ST_EXP_P;
                end
                ST_PSQ: if (m_done && r_b == 3'd4) begin
                    r_pw_ok <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_LEN: if (m_done) begin
                    r_ctx   <= CTX_E1;
                    r_state <= ST_EXP;
                end
                ST_EXP: begin
                    if (|r_arg[63:30]) r_state <= (r_ctx == CTX_E1) ? ST_LEN2 : ST_R2;
                    else               r_state <= ST_SER_M;
                end
                ST_EXP_P: if (r_b == 3'd6) begin
                    r_state <= (r_ctx == CTX_E1) ? ST_LEN2 : ST_R2;
                end
                ST_LEN2: if (m_done) begin
                    r_ctx   <= CTX_E2;
                    r_state <= ST_EXP;
                end
                ST_R2:   if (m_done) r_state <= ST_K2SQ;
                ST_K2SQ: if (m_done) r_state <= ST_DIV;
                ST_DIV:  if (d_done && r_dk == 3'd5) r_state <= ST_ENT;
                ST_ENT:  if (e_nomul || (m_done && e_fin)) r_state <= ST_EMIT;
                ST_EMIT: if (oq_push) r_state <= e_last ? ST_IDLE : ST_ENT;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Checks
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("result queue count out of range");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |-> (r_state == ST_IDLE && r_pw_ok))
        else $error("request taken while sequencer busy");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_done || d_done) |-> r_busy)
        else $error("unit completion without outstanding operation");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (oq_push && out_res.last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after last entry");

endmodule

// ===== src/f84_transition_probabilities.sv =====
// F84 transition probability block: register file, front queue, back end.
// Depends on f84tp_pkg, f84tp_front, f84tp_core.
//
//   Requests enter through a queue interface: an item is taken when push is
//   high and full is low. The oldest result sits on o_row/o_col/o_value/o_last
//   while empty is low and is taken when pop is high. A whole-matrix request
//   yields 16 entries in row-major order, a single-entry request one; o_last
//   marks the final one. Registers are written over the cfg channel (ready
//   always high); the user must write them only while no request is in
//   flight, the block itself does not enforce this.
//   Per request, the two exponentials are computed (21 series terms each, a
//   multiply and a divide per term; a series is skipped when its exponential
//   underflows to zero), then the coefficients and the entries. One request
//   is worked at a time while the two-entry front queue takes the next ones.
//   Reset: registers return to their defaults and the back end builds the
//   powers of e^-1 before it takes the first request.
//   A stalled receiver fills the two-entry result queue and then holds the
//   back end; nothing is dropped.

module f84_transition_probabilities import f84tp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_op,
    input  logic                   i_whole_matrix,
    input  logic [1:0]             i_row_sel,
    input  logic [1:0]             i_col_sel,
    input  logic [WORD_W-1:0]      i_distance,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             o_row,
    output logic [1:0]             o_col,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data
);

    t_cfg    r_cfg;
    t_item   item;
    logic    item_valid, item_pop;
    t_result res;

    assign o_cfg_ready = 1'b1;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_a <= FREQ_W'(4194304);
            r_cfg.freq_c <= FREQ_W'(4194304);
            r_cfg.freq_g <= FREQ_W'(4194304);
            r_cfg.freq_t <= FREQ_W'(4194304);
            r_cfg.kappa  <= WORD_W'(16777216);
            r_cfg.rate   <= WORD_W'(16777216);
            r_cfg.pur    <= FREQ_W'(8388608);
            r_cfg.pyr    <= FREQ_W'(8388608);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FREQ_A: r_cfg.freq_a <= i_cfg_data[FREQ_W-1:0];
                CFG_FREQ_C: r_cfg.freq_c <= i_cfg_data[FREQ_W-1:0];
                CFG_FREQ_G: r_cfg.freq_g <= i_cfg_data[FREQ_W-1:0];
                CFG_FREQ_T: r_cfg.freq_t <= i_cfg_data[FREQ_W-1:0];
                CFG_KAPPA:  r_cfg.kappa  <= i_cfg_data;
                CFG_RATE:   r_cfg.rate   <= i_cfg_data;
                CFG_PUR:    r_cfg.pur    <= i_cfg_data[FREQ_W-1:0];
                CFG_PYR:    r_cfg.pyr    <= i_cfg_data[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    f84tp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_op           (i_op),
        .i_whole_matrix (i_whole_matrix),
        .i_row_sel      (i_row_sel),
        .i_col_sel      (i_col_sel),
        .i_distance     (i_distance),
        .o_item         (item),
        .o_valid        (item_valid),
        .i_take         (item_pop)
    );

    f84tp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .i_cfg        (r_cfg),
        .o_result     (res),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    assign o_row   = res.row;
    assign o_col   = res.col;
    assign o_value = res.value;
    assign o_last  = res.last;

endmodule

// ===== bench/f84_transition_probabilities_test.sv =====
// Self-checking bench for f84_transition_probabilities: random and directed requests,
// checked entry by entry against a bit-exact fixed-point predictor kept in this file.
// Depends on f84tp_pkg and the RTL under src.

module f84_transition_probabilities_test;
    import f84tp_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;   // unused code, entries come out as zero
    localparam logic [63:0] M25 = (64'd1 << 25) - 64'd1;
    localparam logic [63:0] M32 = 64'hFFFF_FFFF;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [1:0]             i_op = '0;
    logic                   i_whole_matrix = 1'b0;
    logic [1:0]             i_row_sel = '0;
    logic [1:0]             i_col_sel = '0;
    logic [WORD_W-1:0]      i_distance = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [1:0]             o_row;
    logic [1:0]             o_col;
    logic [VALUE_WIDTH-1:0] o_value;
    logic                   o_last;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [2:0]             i_cfg_index = '0;
    logic [WORD_W-1:0]      i_cfg_data = '0;

    typedef struct {
        logic [1:0]             row;
        logic [1:0]             col;
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
    } t_entry;

    t_entry entry_q[$];
    int     err_cnt = 0;
    int     hold_cycles = 0;
    bit     no_idle = 0;

    // predictor copy of the register file
    logic [63:0] pi_f[4];
    logic [63:0] kappa_r, rate_r, pur_r, pyr_r;

    f84_transition_probabilities dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic logic [63:0] umulq(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        if (p[127:64] != 0) return '1;
        return p[63:0];
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] from_mag(input bit neg, input logic [63:0] m);
        if (neg) return (m >= (64'd1 << 63)) ? S64_MIN : -$signed(m);
        return (m > 64'(S64_MAX)) ? S64_MAX : $signed(m);
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        return from_mag(a[63] ^ b[63], umulq(mag(a), mag(b), FRAC_BITS));
    endfunction

    function automatic logic signed [63:0] sneg(input logic signed [63:0] a);
        return (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    // (a << FRAC_BITS) / b; a zero divisor counts as one lsb
    function automatic logic signed [63:0] qdiv(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] bb;
        bb = (b == 0) ? 64'd1 : b;
        return $signed((a << FRAC_BITS) / bb);
    endfunction

    function automatic logic [63:0] exp_taylor(input logic [63:0] x);
        logic [63:0] sum, term;
        sum = Q62_ONE;
        term = Q62_ONE;
        for (int n = 1; n <= SER_TERMS; n++) begin
            term = umulq(term, x, 62) / 64'(n);
            if (n % 2 == 1) sum = (sum >= term) ? sum - term : 64'd0;
            else            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] exp_minus(input logic [63:0] x);
        logic [63:0] ip, v, p;
        ip = x >> FRAC_BITS;
        if (ip >= 64) return 64'd0;
        v = exp_taylor((x & (QF_ONE - 1)) << EXP_SHIFT);
        p = exp_taylor(Q62_ONE);
        for (int b = 0; b < NUM_POW; b++) begin
            if (ip[b]) v = umulq(v, p, 62);
            p = umulq(p, p, 62);
        end
        return (v + (64'd1 << (EXP_SHIFT - 1))) >> EXP_SHIFT;
    endfunction

    // expected entries of one accepted request
    task automatic predict_entries(input logic [1:0] op, input logic whole,
                                   input logic [1:0] rs, input logic [1:0] cs,
                                   input logic [31:0] d);
        logic [63:0] l, k2u, s, o;
        logic signed [63:0] e1, e2, r, r2, k2, k2sq, pj, v, pe, ae1, c;
        int cnt;
        logic [1:0] i, j;
        t_entry e;
        l = umulq(rate_r, {32'd0, d}, FRAC_BITS);
        k2u = kappa_r + QF_ONE;
        e1 = $signed(exp_minus(l));
        e2 = $signed(exp_minus(umulq(k2u, l, FRAC_BITS)));
        r = $signed(rate_r);
        r2 = smul(r, r);
        k2 = $signed(k2u);
        k2sq = smul(k2, k2);
        cnt = whole ? 16 : 1;
        for (int k = 0; k < cnt; k++) begin
            i = whole ? 2'(k >> 2) : rs;
            j = whole ? 2'(k & 3) : cs;
            pj = $signed(pi_f[j]);
            v = '0;
            if (i[0] != j[0]) begin
                pe = smul(pj, e1);
                if (op == OP_PROB)    v = smul(pj, $signed(QF_ONE) - e1);
                else if (op == OP_D1) v = smul(r, pe);
                else if (op == OP_D2) v = sneg(smul(r2, pe));
            end else begin
                s = i[0] ? pyr_r : pur_r;
                o = i[0] ? pur_r : pyr_r;
                ae1 = smul(smul(pj, qdiv(o, s)), e1);
                c = (i == j) ? qdiv(pi_f[j ^ 2'd2], s) : sneg(qdiv(pi_f[j], s));
                if (op == OP_PROB)
                    v = sadd(sadd(pj, ae1), smul(c, e2));
                else if (op == OP_D1)
                    v = smul(r, sadd(sneg(ae1), sneg(smul(smul(c, k2), e2))));
                else if (op == OP_D2)
                    v = smul(r2, sadd(ae1, smul(smul(c, k2sq), e2)));
            end
            e.row = i;
            e.col = j;
            e.value = (v > VAL_MAX) ? VAL_MAX[VALUE_WIDTH-1:0] :
                      (v < VAL_MIN) ? VAL_MIN[VALUE_WIDTH-1:0] : v[VALUE_WIDTH-1:0];
            e.last = (k == cnt - 1);
            entry_q.push_back(e);
        end
    endtask

    // ---------------- result side ----------------
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    initial begin : result_check
        int gap;
        t_entry e;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (entry_q.size() == 0) begin
                    report("unexpected entry", 64'({o_row, o_col, o_value}), 64'd0);
                end else begin
                    e = entry_q.pop_front();
                    if (o_row !== e.row)     report("row", 64'(o_row), 64'(e.row));
                    if (o_col !== e.col)     report("col", 64'(o_col), 64'(e.col));
                    if (o_value !== e.value) report("value", 64'(o_value), 64'(e.value));
                    if (o_last !== e.last)   report("last", 64'(o_last), 64'(e.last));
                end
                gap = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ---------------- request side ----------------
    task automatic send_item(input logic [1:0] op, input logic whole, input logic [1:0] rs,
                             input logic [1:0] cs, input logic [31:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_op <= op;
        i_whole_matrix <= whole;
        i_row_sel <= rs;
        i_col_sel <= cs;
        i_distance <= d;
        do @(posedge i_clk); while (full);
        predict_entries(op, whole, rs, cs, d);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        wait (entry_q.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FREQ_A: pi_f[0] = data & M25;
            CFG_FREQ_C: pi_f[1] = data & M25;
            CFG_FREQ_G: pi_f[2] = data & M25;
            CFG_FREQ_T: pi_f[3] = data & M25;
            CFG_KAPPA:  kappa_r = data & M32;
            CFG_RATE:   rate_r  = data & M32;
            CFG_PUR:    pur_r   = data & M25;
            CFG_PYR:    pyr_r   = data & M25;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [31:0] a, input logic [31:0] c,
                                input logic [31:0] g, input logic [31:0] t,
                                input logic [31:0] kap, input logic [31:0] rate,
                                input logic [31:0] pu, input logic [31:0] py);
        set_reg(CFG_FREQ_A, a);
        set_reg(CFG_FREQ_C, c);
        set_reg(CFG_FREQ_G, g);
        set_reg(CFG_FREQ_T, t);
        set_reg(CFG_KAPPA, kap);
        set_reg(CFG_RATE, rate);
        set_reg(CFG_PUR, pu);
        set_reg(CFG_PYR, py);
        i_cfg_valid <= 1'b0;
    endtask

    // consistent random frequencies, sums within range
    task automatic random_config();
        logic [31:0] a, c, g, t;
        a = $urandom_range(0, 1 << 24);
        g = $urandom_range(0, (1 << 24) - a);
        c = $urandom_range(0, 1 << 24);
        t = $urandom_range(0, (1 << 24) - c);
        write_config(a, c, g, t, $urandom_range(0, 8 << 24),
                     $urandom_range(1 << 22, 3 << 24), a + g, c + t);
    endtask

    task automatic random_item();
        logic [31:0] d;
        case ($urandom_range(0, 9))
            0:       d = $urandom();
            1:       d = $urandom_range(0, 255);
            default: d = $urandom_range(0, 32'h0600_0000);
        endcase
        send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), d);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [1:0] ops[4];
        ops = '{OP_PROB, OP_D1, OP_D2, OP_NONE};
        foreach (ops[n]) begin
            send_item(ops[n], 1'b1, 2'd0, 2'd0, 32'h0100_0000);
            send_item(ops[n], 1'b0, 2'd3, 2'd3, 32'd0);
            send_item(ops[n], 1'b0, 2'd1, 2'd2, 32'hFFFF_FFFF);
        end
        // every row and column in single-entry mode
        for (int k = 0; k < 8; k++)
            send_item(OP_PROB, 1'b0, 2'(k >> 1), 2'(k * 3), 32'h0080_0000 + k);
        // whole matrix ignores the selects
        send_item(OP_D1, 1'b1, 2'd3, 2'd1, 32'h0000_0001);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        // zero class sums divide as one lsb; zero rate and kappa
        write_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        for (int k = 0; k < 6; k++) random_item();
        wait_idle();
        // all maxima
        write_config(1 << 24, 1 << 24, 1 << 24, 1 << 24, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     1 << 24, 1 << 24);
        for (int k = 0; k < 6; k++) random_item();
        wait_idle();
        // smallest sums with full frequencies: large quotients
        write_config(1 << 24, 32'd7, 32'd0, 1 << 24, 32'h0200_0000, 32'h0100_0000,
                     32'd1, 32'd1);
        for (int k = 0; k < 6; k++) random_item();
        wait_idle();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 5; phase++) begin
            random_config();
            no_idle = (phase == 2);
            for (int k = 0; k < 75; k++) random_item();
            wait_idle();
        end
        no_idle = 0;
    endtask

    task automatic test_backpressure();
        random_config();
        hold_cycles = 8000;
        for (int k = 0; k < 10; k++)
            send_item(2'($urandom_range(0, 2)), 1'b1, 2'd0, 2'd0,
                      $urandom_range(0, 32'h0400_0000));
        wait_idle();
    endtask

    initial begin : main
        pi_f = '{64'd4194304, 64'd4194304, 64'd4194304, 64'd4194304};
        kappa_r = 64'd16777216;
        rate_r = 64'd16777216;
        pur_r = 64'd8388608;
        pyr_r = 64'd8388608;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random();
        test_backpressure();

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0 && entry_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/f84tp_pkg.sv
src/f84tp_front.sv
src/f84tp_mul.sv
src/f84tp_div.sv
src/f84tp_core.sv
src/f84_transition_probabilities.sv
bench/f84_transition_probabilities_test.sv
